>>> rtl/core/chma_pkg.sv
// Shared constants, sequencer state type and arctangent table for the compass
// heading core. No dependencies; imported by compass_heading_with_moving_average_core.
package chma_pkg;

  // Window length of each axis ring and number of CORDIC micro-rotations
  localparam int unsigned WINDOW       = 5;
  localparam int unsigned CORDIC_STEPS = 16;

  // Sample and ring sum widths
  localparam int unsigned AXIS_W = 16;
  localparam int unsigned SUM_W  = $clog2(WINDOW * 32768) + 1;
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Reciprocal multiply for the window average: floor(n / WINDOW) for n < 2**SUM_W
  localparam int unsigned DIV_SH = SUM_W + 5;
  localparam int unsigned RECIP  = ((2 ** DIV_SH) + WINDOW - 1) / WINDOW;
  localparam int unsigned QUO_W  = 17;

  // Shared multiplier
  localparam int unsigned MUL_W  = 27;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // CORDIC datapath
  localparam int unsigned CRD_W        = 27;
  localparam int unsigned ANG_W        = 26;
  localparam int unsigned PRE_SH       = 8;
  localparam int unsigned CNT_W        = $clog2(CORDIC_STEPS);
  localparam int unsigned TAB_IDX_W    = 5;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int signed   ANG_90       = 90 * 65536;

  // Angle to centidegree conversion and heading wrap
  localparam int signed   CONV_SCALE = 100;
  localparam int signed   CONV_ROUND = 32768;
  localparam int unsigned CONV_SH    = 16;
  localparam int unsigned CD_W       = 20;
  localparam int unsigned H_W        = 21;
  localparam int signed   CD_FULL    = 36000;
  localparam int signed   CD_HALF    = 18000;
  localparam int signed   DECL_RESET = -858;

  // Register map index (byte address 4 * index)
  typedef enum logic [1:0] {
    REG_OFFSET_X    = 2'd0,
    REG_OFFSET_Y    = 2'd1,
    REG_OFFSET_Z    = 2'd2,
    REG_DECLINATION = 2'd3
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_FIN,
    ST_PRE,
    ST_ITER,
    ST_CONV_MUL,
    ST_CONV_FIN,
    ST_DONE
  } seq_state_e;

  // atan(2**-i) in 1/65536 degree, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = ANG_W'(2949120);
      5'd1:    v = ANG_W'(1740967);
      5'd2:    v = ANG_W'(919879);
      5'd3:    v = ANG_W'(466945);
      5'd4:    v = ANG_W'(234379);
      5'd5:    v = ANG_W'(117304);
      5'd6:    v = ANG_W'(58666);
      5'd7:    v = ANG_W'(29335);
      5'd8:    v = ANG_W'(14668);
      5'd9:    v = ANG_W'(7334);
      5'd10:   v = ANG_W'(3667);
      5'd11:   v = ANG_W'(1833);
      5'd12:   v = ANG_W'(917);
      5'd13:   v = ANG_W'(458);
      5'd14:   v = ANG_W'(229);
      5'd15:   v = ANG_W'(115);
      5'd16:   v = ANG_W'(57);
      5'd17:   v = ANG_W'(29);
      5'd18:   v = ANG_W'(14);
      5'd19:   v = ANG_W'(7);
      5'd20:   v = ANG_W'(4);
      5'd21:   v = ANG_W'(2);
      5'd22:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/compass_heading_with_moving_average_core.sv
// Compass heading core: per-axis moving average, offset removal and CORDIC atan2.
// Depends on chma_pkg (constants, state type, arctangent table).
//
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid/tready           tdata: raw_x, raw_y, raw_z
// m_axis    out        tvalid/tready           tdata: field_x, field_y, field_z, heading
// apb       in         psel/penable/pready     offset_x, offset_y, offset_z, declination
//
// Each sample runs from acceptance to a loaded result through the single vectoring CORDIC,
// iterating once per cycle, and the shared multiplier, used once per axis and once for the
// angle scaling. A zero x/y vector skips the iterations. The sequencer returns to idle
// before it takes another sample, so no sample is accepted until the last one is through.
// s_axis_tready is high only while the sequencer is idle; the output register lets the
// sequencer go idle while a loaded result waits.
// Reset clears the rings, running sums, write slot, offsets and declination (-8.58 deg).
// A stalled m_axis holds the result and parks the sequencer until it is taken.
module compass_heading_with_moving_average_core
  import chma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] raw_x, [31:16] raw_y, [47:32] raw_z
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] field_x, [31:16] field_y,
                                      // [47:32] field_z, [63:48] heading
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // State and registers
  seq_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic signed [AXIS_W-1:0] ring_q [3][WINDOW];
  logic signed [SUM_W-1:0]  sum_q  [3];
  logic [SLOT_W-1:0]        slot_q;

  logic signed [AXIS_W-1:0] off_q [3];
  logic signed [AXIS_W-1:0] decl_q;

  logic signed [AXIS_W-1:0] field_q [3];
  logic                     neg_q;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [CRD_W-1:0]  x_q, y_q;
  logic signed [ANG_W-1:0]  a_q;
  logic [AXIS_W-1:0]        heading_q;

  logic        m_valid_q;
  logic [63:0] m_data_q;

  logic                     in_acc;
  logic                     out_free;
  logic [1:0]               ax;
  logic signed [AXIS_W-1:0] smp [3];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign ax       = cnt_q[1:0];

  assign smp[0] = s_axis_tdata[15:0];
  assign smp[1] = s_axis_tdata[31:16];
  assign smp[2] = s_axis_tdata[47:32];

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_OFFSET_X:    prdata = 32'(off_q[0]);
      REG_OFFSET_Y:    prdata = 32'(off_q[1]);
      REG_OFFSET_Z:    prdata = 32'(off_q[2]);
      REG_DECLINATION: prdata = 32'(decl_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
      decl_q   <= AXIS_W'(DECL_RESET);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_OFFSET_X:    off_q[0] <= pwdata[15:0];
        REG_OFFSET_Y:    off_q[1] <= pwdata[15:0];
        REG_OFFSET_Z:    off_q[2] <= pwdata[15:0];
        REG_DECLINATION: decl_q   <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  // Rings and running sums: replace the oldest entry and adjust the sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
        for (int e = 0; e < WINDOW; e++) begin
          ring_q[k][e] <= '0;
        end
      end
      slot_q <= '0;
    end else if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        ring_q[k][slot_q] <= smp[k];
        sum_q[k] <= sum_q[k] + SUM_W'(smp[k]) - SUM_W'(ring_q[k][slot_q]);
      end
      slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  // Shared multiplier operands: window reciprocal or angle scaling
  logic signed [SUM_W-1:0]  sum_sel;
  logic [SUM_W-1:0]         mag, mag_rnd;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  assign sum_sel = sum_q[ax];
  assign mag     = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign mag_rnd = mag + SUM_W'(WINDOW / 2);

  always_comb begin
    if (state_q == ST_DIV_MUL) begin
      mul_a = MUL_W'(mag_rnd);
      mul_b = MUL_W'(RECIP);
    end else begin
      mul_a = MUL_W'(a_q);
      mul_b = MUL_W'(CONV_SCALE);
    end
  end

  assign prod = mul_a * mul_b;

  // Finish one axis: quotient, sign, offset, saturate
  logic [QUO_W-1:0]          quo;
  logic signed [QUO_W:0]     quo_s;
  logic signed [QUO_W+1:0]   diff;
  logic signed [AXIS_W-1:0]  sat;

  assign quo   = prod_q[DIV_SH +: QUO_W];
  assign quo_s = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign diff  = (QUO_W + 2)'(quo_s) - (QUO_W + 2)'(off_q[ax]);

  always_comb begin
    if (diff > $signed((QUO_W + 2)'(32767))) begin
      sat = 16'sh7fff;
    end else if (diff < -$signed((QUO_W + 2)'(32768))) begin
      sat = 16'sh8000;
    end else begin
      sat = AXIS_W'(diff);
    end
  end

  // CORDIC micro-rotation operands
  logic signed [CRD_W-1:0] x_in, y_in, xs, ys;
  logic signed [ANG_W-1:0] tab;
  logic                    zero_vec;

  assign x_in     = CRD_W'(field_q[0]) <<< PRE_SH;
  assign y_in     = CRD_W'(field_q[1]) <<< PRE_SH;
  assign zero_vec = (field_q[0] == '0) && (field_q[1] == '0);
  assign xs       = x_q >>> cnt_q;
  assign ys       = y_q >>> cnt_q;
  assign tab      = atan_entry(TAB_IDX_W'(cnt_q));

  // Centidegrees, less declination, wrapped into [0, 36000)
  logic signed [PROD_W-1:0] rnd;
  logic signed [CD_W-1:0]   cd;
  logic signed [H_W-1:0]    h0, h1, h2;

  assign rnd = prod_q + PROD_W'(CONV_ROUND);
  assign cd  = rnd[CONV_SH +: CD_W];
  assign h0  = H_W'(cd) - H_W'(decl_q);

  always_comb begin
    if (h0 > $signed(H_W'(CD_HALF))) begin
      h1 = h0 - H_W'(CD_FULL);
    end else if (h0 < -$signed(H_W'(CD_HALF))) begin
      h1 = h0 + H_W'(CD_FULL);
    end else begin
      h1 = h0;
    end
    h2 = h1[H_W-1] ? h1 + H_W'(CD_FULL) : h1;
  end

  // Sequencer: state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_DIV_MUL;
          cnt_d   = '0;
        end
      end
      ST_DIV_MUL: state_d = ST_DIV_FIN;
      ST_DIV_FIN: begin
        if (ax == 2'd2) begin
          state_d = ST_PRE;
          cnt_d   = '0;
        end else begin
          state_d = ST_DIV_MUL;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_PRE: begin
        state_d = zero_vec ? ST_CONV_MUL : ST_ITER;
        cnt_d   = '0;
      end
      ST_ITER: begin
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_CONV_MUL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CONV_MUL: state_d = ST_CONV_FIN;
      ST_CONV_FIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath registers advanced by the sequencer
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_DIV_MUL: begin
        prod_q <= prod;
        neg_q  <= sum_sel[SUM_W-1];
      end
      ST_DIV_FIN: field_q[ax] <= sat;
      ST_PRE: begin
        if (zero_vec) begin
          a_q <= '0;
        end else if (x_in[CRD_W-1]) begin
          // Left half plane: turn the vector by a quarter first
          if (!y_in[CRD_W-1]) begin
            x_q <= y_in;
            y_q <= -x_in;
            a_q <= ANG_W'(ANG_90);
          end else begin
            x_q <= -y_in;
            y_q <= x_in;
            a_q <= -ANG_W'(ANG_90);
          end
        end else begin
          x_q <= x_in;
          y_q <= y_in;
          a_q <= '0;
        end
      end
      ST_ITER: begin
        // Rotate toward y = 0
        if (!y_q[CRD_W-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          a_q <= a_q + tab;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          a_q <= a_q - tab;
        end
      end
      ST_CONV_MUL: prod_q <= prod;
      ST_CONV_FIN: heading_q <= AXIS_W'(h2);
      default: ;
    endcase
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      m_data_q <= {heading_q, field_q[2], field_q[1], field_q[0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DIV_MUL) && (cnt_q == '0))
    else $error("accepted sample did not start the averaging pass");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the completion state");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[63:48] < 16'(CD_FULL)))
    else $error("heading outside [0, 36000)");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (32'(cnt_q) < CORDIC_STEPS))
    else $error("CORDIC step count overran");

endmodule

>>> verif/compass_heading_with_moving_average_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for compass_heading_with_moving_average_core: drives magnetometer
// samples and APB register writes and checks every result against a built-in predictor.
// Depends on chma_pkg and the core RTL only.
module compass_heading_with_moving_average_core_tb;
  import chma_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 192;
  localparam int HOLD_CYCLES   = 600;

  // atan(2**-i) in 1/65536 degree
  localparam int ARCTAN_UDEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [15:0] raw_x, [31:16] raw_y, [47:32] raw_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [15:0] field_x, [31:16] field_y,
                                    // [47:32] field_z, [63:48] heading
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int cycles = 0;
  int steady [3];
  int jitter;

  compass_heading_with_moving_average_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Heading predictor and queue of expected results
  class heading_scoreboard;
    logic signed [15:0] ring [3][WINDOW];
    int    slot;
    int    offset [3];
    int    decl;
    logic [63:0] expected_q [$];
    int    errors;
    int    taken;
    string field_label [4] = '{"field_x", "field_y", "field_z", "heading"};

    function new();
      for (int k = 0; k < 3; k++) begin
        offset[k] = 0;
        for (int j = 0; j < int'(WINDOW); j++) ring[k][j] = '0;
      end
      slot   = 0;
      decl   = DECL_RESET;
      errors = 0;
      taken  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(reg_idx_e idx, logic [15:0] value);
      case (idx)
        REG_OFFSET_X:    offset[0] = int'($signed(value));
        REG_OFFSET_Y:    offset[1] = int'($signed(value));
        REG_OFFSET_Z:    offset[2] = int'($signed(value));
        REG_DECLINATION: decl      = int'($signed(value));
        default:         ;
      endcase
    endfunction

    // Ring mean rounded half away from zero, less offset, saturated
    function int axis_field(int k);
      int sum, mag, q, d;
      sum = 0;
      for (int j = 0; j < int'(WINDOW); j++) sum += ring[k][j];
      mag = (sum < 0) ? -sum : sum;
      q   = (mag + int'(WINDOW) / 2) / int'(WINDOW);
      if (sum < 0) q = -q;
      d = q - offset[k];
      if (d > 32767)  d = 32767;
      if (d < -32768) d = -32768;
      return d;
    endfunction

    // Vectoring CORDIC atan2 in centidegrees
    function int bearing_cd(int fy, int fx);
      longint x, y, a, t, xs, ys;
      if (fx == 0 && fy == 0) return 0;
      x = longint'(fx) * 256;
      y = longint'(fy) * 256;
      a = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;  y = -t; a = 90 * 65536;
        end else begin
          x = -y; y = t;  a = -90 * 65536;
        end
      end
      for (int i = 0; i < int'(CORDIC_STEPS) && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; a = a + ARCTAN_UDEG[i];
        end else begin
          x = x - ys; y = y + xs; a = a - ARCTAN_UDEG[i];
        end
      end
      return int'((a * 100 + 32768) >>> 16);
    endfunction

    // Note an accepted sample and queue its result
    function void note_sample(logic [47:0] word);
      int f [3];
      int h;
      for (int k = 0; k < 3; k++) ring[k][slot] = word[16*k +: 16];
      slot = (slot + 1) % int'(WINDOW);
      for (int k = 0; k < 3; k++) f[k] = axis_field(k);
      h = bearing_cd(f[1], f[0]) - decl;
      if (h > 18000) h -= 36000;
      else if (h < -18000) h += 36000;
      if (h < 0) h += 36000;
      expected_q.push_back({16'(h), 16'(f[2]), 16'(f[1]), 16'(f[0])});
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] want;
      taken++;
      if (expected_q.size() == 0) begin
        $display("%0t: result 0x%016h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got[16*k +: 16] !== want[16*k +: 16]) begin
          $display("%0t: %s expected 0x%04h, got 0x%04h", $time, field_label[k],
                   want[16*k +: 16], got[16*k +: 16]);
          errors++;
        end
      end
    endfunction
  endclass

  heading_scoreboard sb = new();

  // Clock
  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check each result request as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Result sink: stall patterns per segment, plus two long hold-offs
  initial begin : result_sink
    int mode, seg_len, period, phase, holds;
    holds = 0;
    @(posedge rst_ni);
    forever begin
      if (holds < 2 && sb.taken >= 300 + 700 * holds) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds++;
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(16, 200);
      period  = $urandom_range(2, 8);
      phase   = 0;
      repeat (seg_len) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = $urandom_range(0, 1);
          2:       m_axis_tready = (phase == 0);
          default: m_axis_tready = ($urandom_range(0, 4) == 0);
        endcase
        phase = (phase + 1) % period;
      end
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767)  return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic int wild_axis();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // Steady field with jitter, with the odd wild axis
  function automatic logic [47:0] next_sample();
    logic [47:0] word;
    int v;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 9) == 0) v = wild_axis();
      else v = clamp16(steady[k] + int'($urandom_range(0, 2 * jitter)) - jitter);
      word[16*k +: 16] = 16'(v);
    end
    return word;
  endfunction

  // Choose a new steady field: zero, weak, moderate or full scale
  task automatic pick_steady();
    int kind, mag;
    kind = $urandom_range(0, 9);
    mag  = (kind < 1) ? 0 : (kind < 4) ? 300 : (kind < 8) ? 8000 : 32767;
    for (int k = 0; k < 3; k++)
      steady[k] = (mag == 0) ? 0 : int'($urandom_range(0, 2 * mag)) - mag;
    jitter = (mag == 0) ? 0 : $urandom_range(0, 64);
  endtask

  function automatic logic [15:0] rand_offset();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'(int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  function automatic logic [15:0] rand_declination();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 36000)) - 18000);
  endfunction

  // Offer one sample request and hold it until accepted; returns at a falling edge
  task automatic offer_sample(logic [47:0] word);
    s_axis_tdata  = word;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(word);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // APB write then read back
  task automatic reg_write(reg_idx_e idx, logic [15:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{16{value[15]}}, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== value) begin
      $display("%0t: register %s read expected 0x%04h, got 0x%04h", $time, idx.name(),
               value, prdata[15:0]);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_all(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                           logic [15:0] dc);
    reg_write(REG_OFFSET_X, ox);
    reg_write(REG_OFFSET_Y, oy);
    reg_write(REG_OFFSET_Z, oz);
    reg_write(REG_DECLINATION, dc);
  endtask

  // Random samples in bursts with random gaps
  task automatic stream_random(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 85) pick_steady();
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) offer_sample(next_sample());
      left -= burst;
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 60)) @(negedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    logic [47:0] fresh [$];
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fresh ring and extremes under reset configuration, then each half plane
    fresh = '{pack3(0, 0, 0), pack3(32767, 0, -32768), pack3(-32768, 32767, 32767),
              pack3(-32768, -32768, 0), pack3(32767, 32767, -32768)};
    foreach (fresh[i]) offer_sample(fresh[i]);
    repeat (3) offer_sample(pack3(-1000, 0, 5));
    repeat (3) offer_sample(pack3(-1000, 1000, 0));
    repeat (3) offer_sample(pack3(-1000, -1000, 0));
    repeat (2) offer_sample(pack3(0, 2000, 0));
    repeat (2) offer_sample(pack3(0, -2000, 0));
    settle();

    // Saturating offsets and declination at both limits and beyond
    write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'(18000));
    offer_sample(pack3(-32768, 32767, -32768));
    offer_sample(pack3(32767, -32768, 32767));
    settle();
    write_all(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
    repeat (2) offer_sample(pack3(5, 5, 5));
    settle();
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    repeat (2) offer_sample(pack3(100, -100, 0));
    settle();

    // Random phases, each under its own configuration
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)      write_all('0, '0, '0, 16'(-18000));
      else if (p == 1) write_all('0, '0, '0, 16'(18000));
      else             write_all(rand_offset(), rand_offset(), rand_offset(),
                                 rand_declination());
      stream_random(PHASE_SAMPLES);
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
